@@ sv/pams_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pams_pkg: shared types and constants for the packed adjacency matrix store
// Item layouts, command and status groups, address mapping of the weight memory.
// ----------------------------------------------------------------------------
package pams_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MEM_WORDS    = MAX_VERTICES * MAX_VERTICES;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int ADDR_W       = $clog2(MEM_WORDS);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VID_W        = 7;
    localparam int W_W          = 32;
    localparam int DEG_W        = 6;

    // operation codes
    localparam logic [3:0] OP_ADD_VERT = 4'd0;
    localparam logic [3:0] OP_SET_VERT = 4'd1;
    localparam logic [3:0] OP_INS_EDGE = 4'd2;
    localparam logic [3:0] OP_SET_EDGE = 4'd3;
    localparam logic [3:0] OP_DEL_EDGE = 4'd4;
    localparam logic [3:0] OP_QRY_EDGE = 4'd5;
    localparam logic [3:0] OP_QRY_VERT = 4'd6;
    localparam logic [3:0] OP_DEGREE   = 4'd7;
    localparam logic [3:0] OP_NEIGHBOR = 4'd8;
    localparam logic [3:0] OP_DEL_VERT = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SELF  = 2'd3;

    typedef struct packed {
        logic [3:0]       op;
        logic [VID_W-1:0] vert_a;
        logic [VID_W-1:0] vert_b;
        logic [W_W-1:0]   weight_in;
    } req_t;

    typedef struct packed {
        logic [W_W-1:0]   weight_out;
        logic             found;
        logic [DEG_W-1:0] degree_count;
        logic [VID_W-1:0] neighbor_id;
        logic [1:0]       status;
        logic             last;
    } rsp_t;

    typedef enum logic [1:0] {
        RES_STATUS,
        RES_EDGE,
        RES_VERT,
        RES_DEGREE
    } res_kind_t;

    typedef struct packed {
        logic             latch;
        logic             rd_en;
        logic [IDX_W-1:0] rd_row;
        logic [IDX_W-1:0] rd_col;
        logic             scan_rd;
        logic             scan_emit;
        logic             copy_rd;
        logic [IDX_W-1:0] cp_row;
        logic [IDX_W-1:0] cp_col;
        logic             wr_en;
        logic             wr_raw;
        logic             wr_zero;
        logic [IDX_W-1:0] wr_row;
        logic [IDX_W-1:0] wr_col;
        logic             cnt_clr;
        logic             vc_inc;
        logic             vc_dec;
        logic             res_en;
        res_kind_t        res_kind;
        logic [1:0]       res_status;
    } cmd_t;

    typedef struct packed {
        logic [3:0]       op;
        logic             a_ok;
        logic             b_ok;
        logic             ab_same;
        logic             full;
        logic             one_vert;
        logic             directed;
        logic             rd_zero;
        logic             nb_none;
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] b_idx;
        logic [IDX_W-1:0] vcnt_lo;
        logic [IDX_W-1:0] last_idx;
    } sts_t;

    // word address of entry (r,c): full square or packed lower triangle
    function automatic logic [ADDR_W-1:0] slot(input logic dir,
                                               input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
        logic [IDX_W-1:0]   hi;
        logic [IDX_W-1:0]   lo;
        logic [2*IDX_W:0]   prod;
        hi = (r < c) ? c : r;
        lo = (r < c) ? r : c;
        prod = (2*IDX_W+1)'(hi) * ((2*IDX_W+1)'(hi) + (2*IDX_W+1)'(1));
        if (dir)
            return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(c));
        else
            return ADDR_W'((prod >> 1) + (2*IDX_W+1)'(lo));
    endfunction

endpackage
`default_nettype wire

@@ sv/pams_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pams_dp: datapath of the adjacency matrix store
// Weight memory, item and count registers, scan and copy pipes, result register.
// ----------------------------------------------------------------------------
module pams_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pams_pkg::req_t  req,
    input  wire logic            cfg_we,
    input  wire logic            cfg_data,
    input  wire pams_pkg::cmd_t  cmd,
    output pams_pkg::sts_t       sts,
    output logic                 res_valid,
    output pams_pkg::rsp_t       res
);

    logic [pams_pkg::W_W-1:0] mem [0:pams_pkg::MEM_WORDS-1];

    pams_pkg::req_t               item_reg;
    logic [pams_pkg::CNT_W-1:0]   vcnt_reg;
    logic                         mode_reg;
    logic [pams_pkg::W_W-1:0]     rd_data_reg;
    logic                         scan_vld_reg;
    logic                         scan_emit_reg;
    logic [pams_pkg::IDX_W-1:0]   tag_col_reg;
    logic                         cp_vld_reg;
    logic [pams_pkg::IDX_W-1:0]   cp_row_reg;
    logic [pams_pkg::IDX_W-1:0]   cp_col_reg;
    logic [pams_pkg::DEG_W-1:0]   deg_reg;
    logic [pams_pkg::DEG_W-1:0]   emit_reg;
    logic                         res_vld_reg;
    pams_pkg::rsp_t               res_reg;

    logic [pams_pkg::ADDR_W-1:0]  rd_addr;
    logic [pams_pkg::ADDR_W-1:0]  wr_addr;
    logic [pams_pkg::W_W-1:0]     wr_data;
    logic                         we;
    logic                         hit;
    logic                         nb_fire;
    pams_pkg::rsp_t               res_next;

    always_comb
    begin
        sts.op       = item_reg.op;
        sts.a_ok     = (item_reg.vert_a != '0) && (pams_pkg::CNT_W'(item_reg.vert_a) <= vcnt_reg);
        sts.b_ok     = (item_reg.vert_b != '0) && (pams_pkg::CNT_W'(item_reg.vert_b) <= vcnt_reg);
        sts.ab_same  = (item_reg.vert_a == item_reg.vert_b);
        sts.full     = (vcnt_reg == pams_pkg::CNT_W'(pams_pkg::MAX_VERTICES));
        sts.one_vert = (vcnt_reg == pams_pkg::CNT_W'(1));
        sts.directed = mode_reg;
        sts.rd_zero  = (rd_data_reg == '0);
        sts.nb_none  = (emit_reg == '0);
        sts.a_idx    = pams_pkg::IDX_W'(item_reg.vert_a - pams_pkg::VID_W'(1));
        sts.b_idx    = pams_pkg::IDX_W'(item_reg.vert_b - pams_pkg::VID_W'(1));
        sts.vcnt_lo  = pams_pkg::IDX_W'(vcnt_reg);
        sts.last_idx = pams_pkg::IDX_W'(vcnt_reg - pams_pkg::CNT_W'(1));
    end

    // copy writeback owns the write port; controller never writes then
    always_comb
    begin
        rd_addr = pams_pkg::slot(mode_reg, cmd.rd_row, cmd.rd_col);
        if (cp_vld_reg)
        begin
            we      = 1'b1;
            wr_addr = pams_pkg::slot(mode_reg, cp_row_reg, cp_col_reg);
            wr_data = rd_data_reg;
        end
        else
        begin
            we      = cmd.wr_en;
            wr_addr = cmd.wr_raw ? pams_pkg::slot(1'b1, cmd.wr_row, cmd.wr_col)
                                 : pams_pkg::slot(mode_reg, cmd.wr_row, cmd.wr_col);
            wr_data = cmd.wr_zero ? '0 : item_reg.weight_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign hit     = scan_vld_reg && (tag_col_reg != sts.a_idx) && (rd_data_reg != '0);
    assign nb_fire = hit && scan_emit_reg && (emit_reg != '1);

    always_comb
    begin
        res_next = '0;
        res_next.last = 1'b1;
        if (nb_fire)
        begin
            res_next.degree_count = deg_reg;
            res_next.neighbor_id  = pams_pkg::VID_W'(tag_col_reg) + pams_pkg::VID_W'(1);
            res_next.last         = ((emit_reg + pams_pkg::DEG_W'(1)) == deg_reg);
        end
        else
        begin
            unique case (cmd.res_kind)
                pams_pkg::RES_STATUS:
                begin
                    res_next.status = cmd.res_status;
                end
                pams_pkg::RES_EDGE:
                begin
                    res_next.weight_out = rd_data_reg;
                    res_next.found      = (rd_data_reg != '0) && !sts.ab_same;
                end
                pams_pkg::RES_VERT:
                begin
                    res_next.weight_out = rd_data_reg;
                    res_next.found      = (rd_data_reg != '0);
                end
                pams_pkg::RES_DEGREE:
                begin
                    res_next.degree_count = deg_reg;
                end
                default:
                begin
                    res_next.status = pams_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= req;
        end
        tag_col_reg <= cmd.rd_col;
        cp_row_reg  <= cmd.cp_row;
        cp_col_reg  <= cmd.cp_col;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            mode_reg      <= 1'b0;
            scan_vld_reg  <= 1'b0;
            scan_emit_reg <= 1'b0;
            cp_vld_reg    <= 1'b0;
            deg_reg       <= '0;
            emit_reg      <= '0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.vc_inc)
            begin
                vcnt_reg <= vcnt_reg + pams_pkg::CNT_W'(1);
            end
            else if (cmd.vc_dec)
            begin
                vcnt_reg <= vcnt_reg - pams_pkg::CNT_W'(1);
            end
            scan_vld_reg  <= cmd.scan_rd;
            scan_emit_reg <= cmd.scan_emit;
            cp_vld_reg    <= cmd.copy_rd;
            if (cmd.cnt_clr)
            begin
                deg_reg  <= '0;
                emit_reg <= '0;
            end
            else
            begin
                if (hit && !scan_emit_reg && (deg_reg != '1))
                begin
                    deg_reg <= deg_reg + pams_pkg::DEG_W'(1);
                end
                if (nb_fire)
                begin
                    emit_reg <= emit_reg + pams_pkg::DEG_W'(1);
                end
            end
            res_vld_reg <= cmd.res_en || nb_fire;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cp_vld_reg && cmd.wr_en))
        else $error("copy writeback collides with a direct write");

    a_no_res_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(nb_fire && cmd.res_en))
        else $error("neighbor result collides with a controller result");

    a_vcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= pams_pkg::CNT_W'(pams_pkg::MAX_VERTICES))
        else $error("vertex count above capacity");

    a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vc_inc |-> !sts.full)
        else $error("vertex added to a full matrix");

endmodule
`default_nettype wire

@@ sv/pams_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pams_ctrl: sequencer of the adjacency matrix store
// Decodes the item, walks rows and columns, issues memory and result commands.
// ----------------------------------------------------------------------------
module pams_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pams_pkg::sts_t  sts,
    output logic                 busy,
    output pams_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_Q_EDGE,
        S_Q_VERT,
        S_SCAN,
        S_SCAN_DRAIN,
        S_DEG_OUT,
        S_NB_SCAN,
        S_NB_DRAIN,
        S_NB_TAIL,
        S_DEL_COPY,
        S_DEL_DRAIN,
        S_DEL_CLR
    } state_t;

    state_t                      state_reg, state_next;
    logic [pams_pkg::IDX_W-1:0]  row_reg, row_next;
    logic [pams_pkg::IDX_W-1:0]  col_reg, col_next;
    logic                        ph_reg, ph_next;
    logic [pams_pkg::IDX_W-1:0]  src_row;
    logic [pams_pkg::IDX_W-1:0]  src_col;
    logic [pams_pkg::IDX_W-1:0]  col_end;
    logic [pams_pkg::IDX_W-1:0]  row_end;

    // rows/cols at or above the deleted vertex shift down by one
    assign src_row = (row_reg >= sts.a_idx) ? row_reg + pams_pkg::IDX_W'(1) : row_reg;
    assign src_col = (col_reg >= sts.a_idx) ? col_reg + pams_pkg::IDX_W'(1) : col_reg;
    assign row_end = sts.last_idx - pams_pkg::IDX_W'(1);
    assign col_end = sts.directed ? row_end : row_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ph_next    = ph_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_raw = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.wr_row = row_reg;
                cmd.wr_col = col_reg;
                {row_next, col_next} = {row_reg, col_reg} + (2*pams_pkg::IDX_W)'(1);
                if ((row_reg == '1) && (col_reg == '1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                cmd.res_kind = pams_pkg::RES_STATUS;
                cmd.res_status = pams_pkg::ST_OK;
                priority if (sts.op > pams_pkg::OP_DEL_VERT)
                begin
                    cmd.res_en = 1'b1;
                end
                else if (sts.op == pams_pkg::OP_ADD_VERT)
                begin
                    cmd.res_en = 1'b1;
                    if (sts.full)
                    begin
                        cmd.res_status = pams_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_row = sts.vcnt_lo;
                        cmd.wr_col = sts.vcnt_lo;
                        cmd.vc_inc = 1'b1;
                    end
                end
                else if (!sts.a_ok || (!sts.b_ok && (sts.op >= pams_pkg::OP_INS_EDGE)
                                       && (sts.op <= pams_pkg::OP_QRY_EDGE)))
                begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = pams_pkg::ST_RANGE;
                end
                else if (sts.op == pams_pkg::OP_SET_VERT)
                begin
                    cmd.res_en = 1'b1;
                    cmd.wr_en  = 1'b1;
                    cmd.wr_row = sts.a_idx;
                    cmd.wr_col = sts.a_idx;
                end
                else if ((sts.op == pams_pkg::OP_SET_EDGE) || (sts.op == pams_pkg::OP_DEL_EDGE))
                begin
                    cmd.res_en = 1'b1;
                    if (sts.ab_same)
                    begin
                        cmd.res_status = pams_pkg::ST_SELF;
                    end
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_zero = (sts.op == pams_pkg::OP_DEL_EDGE);
                        cmd.wr_row  = sts.a_idx;
                        cmd.wr_col  = sts.b_idx;
                    end
                end
                else if ((sts.op == pams_pkg::OP_INS_EDGE) || (sts.op == pams_pkg::OP_QRY_EDGE))
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_row = sts.a_idx;
                    cmd.rd_col = sts.b_idx;
                    state_next = (sts.op == pams_pkg::OP_INS_EDGE) ? S_INS_CHK : S_Q_EDGE;
                end
                else if (sts.op == pams_pkg::OP_QRY_VERT)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_row = sts.a_idx;
                    cmd.rd_col = sts.a_idx;
                    state_next = S_Q_VERT;
                end
                else if ((sts.op == pams_pkg::OP_DEGREE) || (sts.op == pams_pkg::OP_NEIGHBOR))
                begin
                    cmd.cnt_clr = 1'b1;
                    col_next    = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    row_next = '0;
                    col_next = '0;
                    ph_next  = 1'b0;
                    state_next = sts.one_vert ? S_DEL_CLR : S_DEL_COPY;
                end
            end
            S_INS_CHK:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = pams_pkg::RES_STATUS;
                cmd.res_status = pams_pkg::ST_OK;
                cmd.wr_en    = sts.rd_zero;
                cmd.wr_row   = sts.a_idx;
                cmd.wr_col   = sts.b_idx;
                state_next   = S_IDLE;
            end
            S_Q_EDGE:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = pams_pkg::RES_EDGE;
                state_next   = S_IDLE;
            end
            S_Q_VERT:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = pams_pkg::RES_VERT;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.scan_rd = 1'b1;
                cmd.rd_row  = sts.a_idx;
                cmd.rd_col  = col_reg;
                col_next    = col_reg + pams_pkg::IDX_W'(1);
                if (col_reg == sts.last_idx)
                begin
                    state_next = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN:
            begin
                col_next   = '0;
                state_next = (sts.op == pams_pkg::OP_NEIGHBOR) ? S_NB_SCAN : S_DEG_OUT;
            end
            S_DEG_OUT:
            begin
                cmd.res_en   = 1'b1;
                cmd.res_kind = pams_pkg::RES_DEGREE;
                state_next   = S_IDLE;
            end
            S_NB_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                cmd.scan_rd   = 1'b1;
                cmd.scan_emit = 1'b1;
                cmd.rd_row    = sts.a_idx;
                cmd.rd_col    = col_reg;
                col_next      = col_reg + pams_pkg::IDX_W'(1);
                if (col_reg == sts.last_idx)
                begin
                    state_next = S_NB_DRAIN;
                end
            end
            S_NB_DRAIN:
            begin
                state_next = S_NB_TAIL;
            end
            S_NB_TAIL:
            begin
                cmd.res_en   = sts.nb_none;
                cmd.res_kind = pams_pkg::RES_DEGREE;
                state_next   = S_IDLE;
            end
            S_DEL_COPY:
            begin
                cmd.rd_en   = 1'b1;
                cmd.copy_rd = 1'b1;
                cmd.rd_row  = src_row;
                cmd.rd_col  = src_col;
                cmd.cp_row  = row_reg;
                cmd.cp_col  = col_reg;
                if (col_reg == col_end)
                begin
                    col_next = '0;
                    row_next = row_reg + pams_pkg::IDX_W'(1);
                    if (row_reg == row_end)
                    begin
                        state_next = S_DEL_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + pams_pkg::IDX_W'(1);
                end
            end
            S_DEL_DRAIN:
            begin
                row_next   = '0;
                ph_next    = 1'b0;
                state_next = S_DEL_CLR;
            end
            S_DEL_CLR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.wr_row  = ph_reg ? row_reg : sts.last_idx;
                cmd.wr_col  = ph_reg ? sts.last_idx : row_reg;
                ph_next     = !ph_reg;
                if (ph_reg)
                begin
                    row_next = row_reg + pams_pkg::IDX_W'(1);
                    if (row_reg == sts.last_idx)
                    begin
                        cmd.vc_dec     = 1'b1;
                        cmd.res_en     = 1'b1;
                        cmd.res_kind   = pams_pkg::RES_STATUS;
                        cmd.res_status = pams_pkg::ST_OK;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ph_reg    <= ph_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

@@ sv/packed_adjacency_matrix_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packed_adjacency_matrix_store: graph adjacency matrix in one weight memory
// Up to 64 vertices; directed square layout or packed lower triangle.
//
//   channel  signals                    handshake
//   -------  -------------------------  ---------------------------------
//   request  req (req_t)                taken when start && !busy
//   result   res (rsp_t)                one cycle, marked by res_valid
//   config   cfg_data (directed_mode)   written when cfg_we
//
// Flow (n = live vertices): neighbors give one result per neighbor as found;
// delete vertex moves one entry per cycle (n(n-1)/2 packed, (n-1)^2 directed),
// then clears the last row and column (the move is skipped when the only
// vertex goes).
// Reset: a clearing pass writes all 4096 words, one per cycle, busy high.
// Results cannot be stalled; one item is in flight at a time.
// ----------------------------------------------------------------------------
module packed_adjacency_matrix_store (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pams_pkg::req_t  req,
    output logic                 busy,
    output logic                 res_valid,
    output pams_pkg::rsp_t       res,
    input  wire logic            cfg_we,
    input  wire logic            cfg_data
);

    // command/status link between sequencer and datapath
    pams_pkg::cmd_t cmd;
    pams_pkg::sts_t sts;

    pams_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // memory, counters and the result register live here
    pams_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule
`default_nettype wire

@@ sim/packed_adjacency_matrix_store_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_adjacency_matrix_store_tb: self-checking bench for the matrix store
// A behavioral graph model predicts every result item. Directed tests hit each
// operation and error case. Random graph traffic then runs under several
// idle patterns and in both layouts. The results are compared item by item.
// ----------------------------------------------------------------------------
module packed_adjacency_matrix_store_tb;

    // opcodes outside the defined set
    localparam logic [3:0] OP_SPARE_LO = 4'd10;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    logic           clk;
    logic           rst_n;
    logic           start;
    pams_pkg::req_t req;
    logic           busy;
    logic           res_valid;
    pams_pkg::rsp_t res;
    logic           cfg_we;
    logic           cfg_data;

    packed_adjacency_matrix_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // model state: weight words, live vertex count, layout
    logic [31:0]    graph_mem [pams_pkg::MEM_WORDS];
    int             live_verts;
    logic           dir_mode;

    pams_pkg::rsp_t pending_rsp[$];
    int             error_count;
    int             idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 200 ms is far above the slowest run, including the clearing pass
    initial
    begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    function automatic int mem_addr(input int r, input int c);
        int hi;
        int lo;
        if (dir_mode)
            return r * pams_pkg::MAX_VERTICES + c;
        hi = (r < c) ? c : r;
        lo = (r < c) ? r : c;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    function automatic int row_degree(input int a);
        int n;
        n = 0;
        for (int j = 0; j < live_verts; j++)
            if (j != a && graph_mem[mem_addr(a, j)] != 0)
                n++;
        return (n > 63) ? 63 : n;
    endfunction

    function automatic pams_pkg::rsp_t mk_rsp(input logic [31:0] w, input logic f,
                                              input logic [5:0] deg, input logic [6:0] nb,
                                              input logic [1:0] st, input logic lst);
        pams_pkg::rsp_t r;
        r.weight_out   = w;
        r.found        = f;
        r.degree_count = deg;
        r.neighbor_id  = nb;
        r.status       = st;
        r.last         = lst;
        return r;
    endfunction

    function automatic pams_pkg::rsp_t status_rsp(input logic [1:0] st);
        return mk_rsp(32'd0, 1'b0, 6'd0, 7'd0, st, 1'b1);
    endfunction

    // Applies one item to the model and queues its expected result items.
    task automatic predict_graph_op(input pams_pkg::req_t it);
        int          a;
        int          b;
        int          deg;
        int          k;
        int          n;
        logic [31:0] w;
        a = int'(it.vert_a) - 1;
        b = int'(it.vert_b) - 1;
        if (it.op > pams_pkg::OP_DEL_VERT)
        begin
            pending_rsp.push_back(status_rsp(pams_pkg::ST_OK));
            return;
        end
        if (it.op == pams_pkg::OP_ADD_VERT)
        begin
            if (live_verts >= pams_pkg::MAX_VERTICES)
            begin
                pending_rsp.push_back(status_rsp(pams_pkg::ST_FULL));
                return;
            end
            live_verts++;
            graph_mem[mem_addr(live_verts - 1, live_verts - 1)] = it.weight_in;
            pending_rsp.push_back(status_rsp(pams_pkg::ST_OK));
            return;
        end
        // invalid ids: vert_a always, vert_b for the edge group
        if (it.vert_a < 1 || it.vert_a > live_verts ||
            (it.op >= pams_pkg::OP_INS_EDGE && it.op <= pams_pkg::OP_QRY_EDGE &&
             (it.vert_b < 1 || it.vert_b > live_verts)))
        begin
            pending_rsp.push_back(status_rsp(pams_pkg::ST_RANGE));
            return;
        end
        case (it.op)
            pams_pkg::OP_SET_VERT: graph_mem[mem_addr(a, a)] = it.weight_in;
            pams_pkg::OP_INS_EDGE:
                if (graph_mem[mem_addr(a, b)] == 0)
                    graph_mem[mem_addr(a, b)] = it.weight_in;
            pams_pkg::OP_SET_EDGE, pams_pkg::OP_DEL_EDGE:
            begin
                if (a == b)
                begin
                    pending_rsp.push_back(status_rsp(pams_pkg::ST_SELF));
                    return;
                end
                graph_mem[mem_addr(a, b)] =
                    (it.op == pams_pkg::OP_SET_EDGE) ? it.weight_in : 32'd0;
            end
            pams_pkg::OP_QRY_EDGE:
            begin
                w = graph_mem[mem_addr(a, b)];
                pending_rsp.push_back(mk_rsp(w, (w != 0) && (a != b), 6'd0, 7'd0,
                                             pams_pkg::ST_OK, 1'b1));
                return;
            end
            pams_pkg::OP_QRY_VERT:
            begin
                w = graph_mem[mem_addr(a, a)];
                pending_rsp.push_back(mk_rsp(w, w != 0, 6'd0, 7'd0, pams_pkg::ST_OK, 1'b1));
                return;
            end
            pams_pkg::OP_DEGREE:
            begin
                pending_rsp.push_back(mk_rsp(32'd0, 1'b0, 6'(row_degree(a)), 7'd0,
                                             pams_pkg::ST_OK, 1'b1));
                return;
            end
            pams_pkg::OP_NEIGHBOR:
            begin
                deg = row_degree(a);
                k = 0;
                for (int j = 0; j < live_verts && k < 63; j++)
                    if (j != a && graph_mem[mem_addr(a, j)] != 0)
                    begin
                        pending_rsp.push_back(mk_rsp(32'd0, 1'b0, 6'(deg), 7'(j + 1),
                                                     pams_pkg::ST_OK, 1'b0));
                        k++;
                    end
                if (k == 0)
                    pending_rsp.push_back(mk_rsp(32'd0, 1'b0, 6'(deg), 7'd0,
                                                 pams_pkg::ST_OK, 1'b1));
                else
                    pending_rsp[$].last = 1'b1;
                return;
            end
            default:
            begin
                // delete vertex: compact rows/cols above it, clear the last
                n = live_verts;
                for (int r = 0; r + 1 < n; r++)
                    for (int c = 0; c < (dir_mode ? n - 1 : r + 1); c++)
                        graph_mem[mem_addr(r, c)] =
                            graph_mem[mem_addr(r >= a ? r + 1 : r, c >= a ? c + 1 : c)];
                for (int j = 0; j < n; j++)
                begin
                    graph_mem[mem_addr(n - 1, j)] = 0;
                    graph_mem[mem_addr(j, n - 1)] = 0;
                end
                live_verts = n - 1;
            end
        endcase
        pending_rsp.push_back(status_rsp(pams_pkg::ST_OK));
    endtask

    task automatic report_mismatch(input string what, input pams_pkg::rsp_t got,
                                   input pams_pkg::rsp_t want);
        error_count++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    // result checker: results can't be stalled, sampled at every edge
    always @(posedge clk)
    begin
        pams_pkg::rsp_t e;
        if (rst_n && res_valid)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected result item", res, '0);
            else
            begin
                e = pending_rsp.pop_front();
                if (res !== e)
                    report_mismatch("result item", res, e);
            end
        end
    end

    // Sends one item: random idle gap, then hold start until accepted.
    task automatic send_item(input logic [3:0] op, input int va, input int vb,
                             input logic [31:0] w);
        pams_pkg::req_t it;
        logic [63:0]    noise;
        it.op        = op;
        it.vert_a    = va[6:0];
        it.vert_b    = vb[6:0];
        it.weight_in = w;
        while ($urandom_range(99) < idle_pct)
        begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            req   <= noise[$bits(pams_pkg::req_t)-1:0];
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_graph_op(it);
    endtask

    // Waits for all results and for the store to go idle, plus a margin.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_rsp.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
        dir_mode = m;
    endtask

    task automatic test_directed_ops();
        idle_pct = 0;
        send_item(pams_pkg::OP_SET_VERT, 1, 0, 32'h1);  // no vertex yet: out of range
        send_item(pams_pkg::OP_ADD_VERT, 0, 0, 32'hFFFF_FFFF);
        send_item(pams_pkg::OP_ADD_VERT, 0, 0, 32'h0);  // zero weight, still live
        send_item(pams_pkg::OP_ADD_VERT, 0, 0, 32'h55);
        send_item(pams_pkg::OP_INS_EDGE, 1, 2, 32'hFFFF_FFFF);
        send_item(pams_pkg::OP_INS_EDGE, 2, 1, 32'h7);  // slot taken, unchanged
        send_item(pams_pkg::OP_INS_EDGE, 2, 2, 32'h9);  // diagonal fill
        send_item(pams_pkg::OP_SET_EDGE, 3, 3, 32'h1);  // self loop
        send_item(pams_pkg::OP_DEL_EDGE, 1, 1, 32'h0);
        send_item(pams_pkg::OP_SET_EDGE, 3, 1, 32'h8000_0000);
        send_item(pams_pkg::OP_QRY_EDGE, 1, 3, 32'h0);
        send_item(pams_pkg::OP_QRY_EDGE, 1, 1, 32'h0);  // diagonal, found 0
        send_item(pams_pkg::OP_QRY_VERT, 2, 0, 32'h0);
        send_item(pams_pkg::OP_DEGREE, 1, 0, 32'h0);
        send_item(pams_pkg::OP_NEIGHBOR, 1, 0, 32'h0);
        send_item(pams_pkg::OP_NEIGHBOR, 2, 0, 32'h0);
        send_item(pams_pkg::OP_QRY_EDGE, 1, 64, 32'h0);
        send_item(pams_pkg::OP_QRY_VERT, 127, 0, 32'h0);
        send_item(OP_SPARE_HI, 127, 127, 32'hFFFF_FFFF);
        send_item(OP_SPARE_LO, 0, 0, 32'h0);
        send_item(pams_pkg::OP_DEL_EDGE, 1, 3, 32'h0);
        send_item(pams_pkg::OP_DEL_VERT, 1, 0, 32'h0);
        send_item(pams_pkg::OP_QRY_EDGE, 1, 2, 32'h0);
        send_item(pams_pkg::OP_SET_VERT, 2, 0, 32'hA5A5_A5A5);
    endtask

    // Fills to 64 vertices, hits the full case, then empties a few.
    task automatic test_full_matrix();
        while (live_verts < pams_pkg::MAX_VERTICES)
            send_item(pams_pkg::OP_ADD_VERT, 0, 0, $urandom);
        send_item(pams_pkg::OP_ADD_VERT, 0, 0, 32'h1);
        for (int j = 2; j <= pams_pkg::MAX_VERTICES; j++)
            send_item(pams_pkg::OP_SET_EDGE, 1, j, $urandom | 1);
        send_item(pams_pkg::OP_NEIGHBOR, 1, 0, 32'h0);  // 63 neighbors
        send_item(pams_pkg::OP_DEGREE, 1, 0, 32'h0);
        send_item(pams_pkg::OP_DEL_VERT, 64, 0, 32'h0);
        send_item(pams_pkg::OP_DEL_VERT, 1, 0, 32'h0);
        send_item(pams_pkg::OP_DEL_VERT, 1, 0, 32'h0);
    endtask

    // Random traffic; mostly valid ids, some noise. Keeps the graph small.
    task automatic test_random_traffic(input int items);
        int          op;
        int          va;
        int          vb;
        logic [31:0] w;
        for (int i = 0; i < items; i++)
        begin
            op = $urandom_range(99);
            if (op < 8 || live_verts < 2)
                op = (live_verts > 12) ? int'(pams_pkg::OP_DEL_VERT)
                                       : int'(pams_pkg::OP_ADD_VERT);
            else if (op < 12)
                op = $urandom_range(15);
            else
                op = $urandom_range(1, 9);
            if (op == pams_pkg::OP_DEL_VERT && live_verts < 3)
                op = int'(pams_pkg::OP_ADD_VERT);
            if ($urandom_range(9) == 0)
            begin
                va = $urandom_range(127);
                vb = $urandom_range(127);
            end
            else
            begin
                va = $urandom_range(1, live_verts > 0 ? live_verts : 1);
                vb = $urandom_range(1, live_verts > 0 ? live_verts : 1);
            end
            case ($urandom_range(3))
                0: w = 32'h0;
                1: w = 32'hFFFF_FFFF;
                default: w = $urandom;
            endcase
            send_item(op[3:0], va, vb, w);
        end
    endtask

    initial
    begin
        error_count = 0;
        live_verts  = 0;
        dir_mode    = 1'b0;
        idle_pct    = 0;
        for (int i = 0; i < pams_pkg::MEM_WORDS; i++)
            graph_mem[i] = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass runs with busy high; write_mode waits on it via drain_results

        write_mode(1'b0);
        test_directed_ops();
        test_full_matrix();
        write_mode(1'b1);                               // reads old words in new layout
        test_random_traffic(30);
        idle_pct = 55;
        test_random_traffic(30);
        drain_results();                                // sender holds off until empty
        write_mode(1'b0);
        idle_pct = 25;
        test_random_traffic(30);
        idle_pct = 0;
        test_random_traffic(30);

        drain_results();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
